// ===== rtl/tsd_pkg.sv =====
// Package for the track stream decoder: event kinds, token codes and the
// result record type. No dependencies.
package tsd_pkg;

    typedef enum logic [2:0] {
        EV_NOTE   = 3'd0,
        EV_VOLUME = 3'd1,
        EV_SPEED  = 3'd2,
        EV_END    = 3'd3,
        EV_FINISH = 3'd4
    } event_kind_t;

    // Low six bits of the first byte of a token
    localparam logic [5:0] CODE_VOLUME  = 6'h3D;
    localparam logic [5:0] CODE_PAUSE   = 6'h3E;
    localparam logic [5:0] CODE_SPECIAL = 6'h3F;

    // Top two bits qualifying the special code
    localparam logic [1:0] SPECIAL_UNDEF = 2'd1;
    localparam logic [1:0] SPECIAL_STOP  = 2'd2;
    localparam logic [1:0] SPECIAL_END   = 2'd3;

    typedef struct packed {
        event_kind_t kind;
        logic [7:0]  row;
        logic [5:0]  note;
        logic [5:0]  instrument;
        logic [3:0]  volume;
        logic [7:0]  speed;
        logic        done;
    } track_event_t;

endpackage

// ===== rtl/tracker_track_stream_decoder.sv =====
// Track stream decoder top level: byte-wide token decode, row counter and
// output register with a skid stage. Depends on tsd_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one track byte per item,
//   with final_byte marking the last byte of a track. Output channel
//   (out_valid / out_stall) carries zero or one row event per input item.
//   An item is moved at a clock edge where valid is high and stall is low.
//   The event caused by a byte is registered in the output register, or in
//   the skid register while the output waits. Throughput: one byte per cycle
//   while in_stall is low; the decode of a byte is a single pass of logic from
//   the stored token state. Two-byte tokens emit any event on the second byte.
//   When the receiver stalls, the waiting event holds on the output
//   register and the next event is caught in the skid register; in_stall
//   rises only while the skid register is full, so at most two events
//   queue up before the input side stops.
//   Reset clears the token state, row counter and both valid flags. After
//   the final byte of a track all decoder state returns to its reset value,
//   ready for the next track.
module tracker_track_stream_decoder
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] stream_byte,
    input  logic       final_byte,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] event_kind,
    output logic [7:0] row_index,
    output logic [5:0] note_value,
    output logic [5:0] instrument_number,
    output logic [3:0] volume_level,
    output logic [7:0] speed_value,
    output logic       track_done
);

    logic       await_reg, await_next;
    logic [7:0] held_reg, held_next;
    logic [7:0] row_reg, row_next;
    logic       stopped_reg, stopped_next;

    logic       out_valid_reg, skid_valid_reg;
    tsd_pkg::track_event_t out_reg, skid_reg;

    tsd_pkg::track_event_t res;
    logic       res_produce;
    logic       stop;
    logic       in_fire, out_fire, res_valid;

    logic [5:0] lo;
    logic [1:0] top;
    logic [3:0] held_vol;

    assign in_stall  = skid_valid_reg;
    assign in_fire   = in_valid && !skid_valid_reg;
    assign out_fire  = out_valid_reg && !out_stall;
    assign res_valid = in_fire && res_produce;

    assign lo       = stream_byte[5:0];
    assign top      = stream_byte[7:6];
    assign held_vol = {stream_byte[1:0], held_reg[7:6]};

    always_comb
    begin
        await_next   = await_reg;
        held_next    = held_reg;
        row_next     = row_reg;
        stopped_next = stopped_reg;
        stop         = 1'b0;
        res_produce  = 1'b0;
        res          = '{kind: tsd_pkg::EV_FINISH, row: row_reg, note: 6'd0,
                         instrument: 6'd0, volume: 4'd0, speed: 8'd0, done: 1'b1};

        if (stopped_reg)
        begin
            // ignore bytes until the final one, then clear
            if (final_byte)
            begin
                stopped_next = 1'b0;
                row_next     = 8'd0;
                await_next   = 1'b0;
                held_next    = 8'd0;
            end
        end
        else
        begin
            if (await_reg)
            begin
                await_next = 1'b0;
                held_next  = 8'd0;
                if (held_reg[5:0] == tsd_pkg::CODE_VOLUME)
                begin
                    res_produce = 1'b1;
                    res.kind    = tsd_pkg::EV_VOLUME;
                    res.volume  = held_vol;
                    res.done    = 1'b0;
                    row_next    = row_reg + 8'd1;
                end
                else if (held_reg[5:0] == tsd_pkg::CODE_PAUSE)
                begin
                    if (stream_byte == 8'd0)
                    begin
                        // infinite pause ends the track
                        res_produce = 1'b1;
                        stop        = 1'b1;
                    end
                    else
                    begin
                        row_next = row_reg + stream_byte;
                    end
                end
                else if (held_reg[5:0] == tsd_pkg::CODE_SPECIAL)
                begin
                    res_produce = 1'b1;
                    res.kind    = tsd_pkg::EV_SPEED;
                    res.speed   = stream_byte;
                    res.done    = 1'b0;
                end
                else
                begin
                    res_produce    = 1'b1;
                    res.kind       = tsd_pkg::EV_NOTE;
                    res.note       = held_reg[5:0];
                    res.instrument = stream_byte[7:2];
                    res.volume     = held_vol;
                    res.done       = 1'b0;
                    row_next       = row_reg + 8'd1;
                end
            end
            else
            begin
                if (lo == tsd_pkg::CODE_PAUSE && top != 2'd0)
                begin
                    row_next = row_reg + {6'd0, top};
                end
                else if (lo == tsd_pkg::CODE_SPECIAL && top == tsd_pkg::SPECIAL_UNDEF)
                begin
                    // undefined code: one byte, no effect
                end
                else if (lo == tsd_pkg::CODE_SPECIAL && top == tsd_pkg::SPECIAL_STOP)
                begin
                    res_produce = 1'b1;
                    stop        = 1'b1;
                end
                else if (lo == tsd_pkg::CODE_SPECIAL && top == tsd_pkg::SPECIAL_END)
                begin
                    res_produce = 1'b1;
                    stop        = 1'b1;
                    res.kind    = tsd_pkg::EV_END;
                    // end mark sits on the previous row, or row 0
                    res.row     = (row_reg == 8'd0) ? 8'd0 : row_reg - 8'd1;
                end
                else if (!final_byte)
                begin
                    await_next = 1'b1;
                    held_next  = stream_byte;
                end
            end

            if (final_byte)
            begin
                if (!res_produce)
                begin
                    res_produce = 1'b1;
                    res.row     = row_next;
                end
                res.done     = 1'b1;
                await_next   = 1'b0;
                held_next    = 8'd0;
                row_next     = 8'd0;
                stopped_next = 1'b0;
            end
            else if (stop)
            begin
                stopped_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            await_reg   <= 1'b0;
            held_reg    <= 8'd0;
            row_reg     <= 8'd0;
            stopped_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            await_reg   <= await_next;
            held_reg    <= held_next;
            row_reg     <= row_next;
            stopped_reg <= stopped_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (out_valid_reg && !out_fire)
        begin
            skid_valid_reg <= res_valid;
        end
        else
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            // drain the skid register into the output register
            if (out_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (out_valid_reg && !out_fire)
        begin
            if (res_valid)
            begin
                skid_reg <= res;
            end
        end
        else if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid         = out_valid_reg;
    assign event_kind        = out_reg.kind;
    assign row_index         = out_reg.row;
    assign note_value        = out_reg.note;
    assign instrument_number = out_reg.instrument;
    assign volume_level      = out_reg.volume;
    assign speed_value       = out_reg.speed;
    assign track_done        = out_reg.done;

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    a_no_await_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        !(await_reg && stopped_reg))
        else $error("held token while track stopped");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && final_byte) |=> (row_reg == 8'd0 && !await_reg && !stopped_reg))
        else $error("state not cleared after final byte");

    a_terminal_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.kind == tsd_pkg::EV_END ||
                           out_reg.kind == tsd_pkg::EV_FINISH)) |-> out_reg.done)
        else $error("terminal event without track_done");

    a_final_gives_event: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && final_byte && !stopped_reg) |-> res_valid)
        else $error("final byte of a live track produced no event");

endmodule

// ===== dv/tracker_track_stream_decoder_tb.sv =====
// Self-checking testbench for the track stream decoder: directed token cases,
// random tracks, output hold-off and drain pauses against a cycle-free predictor.
// Depends on tsd_pkg and tracker_track_stream_decoder.
module tracker_track_stream_decoder_tb;

    localparam int HOLD_CYCLES  = 50;
    localparam int DRAIN_GUARD  = 5000;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    logic [7:0] stream_byte = 8'h00;
    logic       final_byte  = 1'b0;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    logic [2:0] event_kind;
    logic [7:0] row_index;
    logic [5:0] note_value;
    logic [5:0] instrument_number;
    logic [3:0] volume_level;
    logic [7:0] speed_value;
    logic       track_done;

    // Predictor state
    logic       pending_second;
    logic [7:0] held_byte;
    logic [7:0] row_count;
    logic       track_stopped;

    tsd_pkg::track_event_t expected_events[$];
    tsd_pkg::track_event_t want_event;
    logic [7:0]            track_bytes[$];

    int  errors         = 0;
    int  items_sent     = 0;
    int  tracks_sent    = 0;
    int  events_checked = 0;
    bit  idling         = 1'b1;
    bit  hold_req       = 1'b0;
    bit  hold_active    = 1'b0;
    int  stall_left     = 0;

    tracker_track_stream_decoder i_dut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .stream_byte       (stream_byte),
        .final_byte        (final_byte),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .event_kind        (event_kind),
        .row_index         (row_index),
        .note_value        (note_value),
        .instrument_number (instrument_number),
        .volume_level      (volume_level),
        .speed_value       (speed_value),
        .track_done        (track_done)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got_v,
                               input logic [7:0] want_v);
        if (got_v !== want_v)
            report_mismatch($sformatf("%s got %0h expected %0h (event %0d)",
                                      name, got_v, want_v, events_checked));
    endtask

    task automatic clear_track;
        pending_second = 1'b0;
        held_byte      = 8'h00;
        row_count      = 8'h00;
        track_stopped  = 1'b0;
    endtask

    // Work out the event, if any, that one accepted byte causes
    task automatic decode_byte(input logic [7:0] b, input logic is_last);
        tsd_pkg::track_event_t ev;
        logic         hit;
        logic         halt;
        logic [5:0]   lo;
        logic [1:0]   top;
        ev   = '0;
        hit  = 1'b0;
        halt = 1'b0;
        if (track_stopped)
        begin
            if (is_last)
                clear_track();
            return;
        end
        if (pending_second)
        begin
            lo  = held_byte[5:0];
            top = held_byte[7:6];
            pending_second = 1'b0;
            held_byte      = 8'h00;
            ev.row = row_count;
            if (lo == tsd_pkg::CODE_VOLUME)
            begin
                ev.kind   = tsd_pkg::EV_VOLUME;
                ev.volume = {b[1:0], top};
                row_count = row_count + 8'd1;
                hit = 1'b1;
            end
            else if (lo == tsd_pkg::CODE_PAUSE)
            begin
                if (b == 8'h00)
                begin
                    ev.kind = tsd_pkg::EV_FINISH;
                    ev.done = 1'b1;
                    hit  = 1'b1;
                    halt = 1'b1;
                end
                else
                    row_count = row_count + b;
            end
            else if (lo == tsd_pkg::CODE_SPECIAL)
            begin
                ev.kind  = tsd_pkg::EV_SPEED;
                ev.speed = b;
                hit = 1'b1;
            end
            else
            begin
                ev.kind       = tsd_pkg::EV_NOTE;
                ev.note       = lo;
                ev.instrument = b[7:2];
                ev.volume     = {b[1:0], top};
                row_count     = row_count + 8'd1;
                hit = 1'b1;
            end
        end
        else
        begin
            lo  = b[5:0];
            top = b[7:6];
            if (lo == tsd_pkg::CODE_PAUSE && top != 2'd0)
                row_count = row_count + {6'd0, top};
            else if (lo == tsd_pkg::CODE_SPECIAL && top == tsd_pkg::SPECIAL_UNDEF)
                ;
            else if (lo == tsd_pkg::CODE_SPECIAL && top == tsd_pkg::SPECIAL_STOP)
            begin
                ev.kind = tsd_pkg::EV_FINISH;
                ev.row  = row_count;
                ev.done = 1'b1;
                hit  = 1'b1;
                halt = 1'b1;
            end
            else if (lo == tsd_pkg::CODE_SPECIAL && top == tsd_pkg::SPECIAL_END)
            begin
                // The end mark sits on the row before, but never below row 0
                ev.kind = tsd_pkg::EV_END;
                ev.row  = (row_count == 8'h00) ? 8'h00 : row_count - 8'd1;
                ev.done = 1'b1;
                hit  = 1'b1;
                halt = 1'b1;
            end
            else if (!is_last)
            begin
                pending_second = 1'b1;
                held_byte      = b;
            end
        end
        if (is_last)
        begin
            if (!hit)
            begin
                ev      = '0;
                ev.kind = tsd_pkg::EV_FINISH;
                ev.row  = row_count;
                ev.done = 1'b1;
                hit = 1'b1;
            end
            else
                ev.done = 1'b1;
            clear_track();
        end
        else if (halt)
            track_stopped = 1'b1;
        if (hit)
            expected_events.push_back(ev);
    endtask

    // Offer one item and hold it until taken; maybe idle afterwards
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        in_valid    <= 1'b1;
        stream_byte <= b;
        final_byte  <= is_last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decode_byte(b, is_last);
        items_sent++;
        if (is_last)
            tracks_sent++;
        if (idling && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    task automatic wait_drained;
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (expected_events.size() != 0 && guard < DRAIN_GUARD)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (3) @(posedge clk);
    endtask

    task automatic build_track;
        int         n_tokens;
        int         t;
        int         pick;
        bit         halted;
        logic [1:0] top;
        logic [5:0] lo;
        logic [7:0] b;
        track_bytes.delete();
        n_tokens = $urandom_range(1, 20);
        halted   = 1'b0;
        for (t = 0; t < n_tokens && !halted; t++)
        begin
            pick = $urandom_range(0, 15);
            top  = 2'($urandom_range(0, 3));
            b    = 8'($urandom);
            if (pick <= 6)
            begin
                lo = 6'($urandom_range(0, 60));
                track_bytes.push_back({top, lo});
                track_bytes.push_back(b);
            end
            else if (pick <= 8)
            begin
                track_bytes.push_back({top, tsd_pkg::CODE_VOLUME});
                track_bytes.push_back(b);
            end
            else if (pick == 9)
            begin
                track_bytes.push_back({2'd0, tsd_pkg::CODE_SPECIAL});
                track_bytes.push_back(b);
            end
            else if (pick <= 11)
            begin
                top = 2'($urandom_range(1, 3));
                track_bytes.push_back({top, tsd_pkg::CODE_PAUSE});
            end
            else if (pick == 12)
            begin
                b = 8'($urandom_range(1, 255));
                track_bytes.push_back({2'd0, tsd_pkg::CODE_PAUSE});
                track_bytes.push_back(b);
            end
            else if (pick == 13)
                track_bytes.push_back(b);
            else if (pick == 14)
            begin
                halted = 1'b1;
                case ($urandom_range(0, 2))
                    0:
                    begin
                        track_bytes.push_back({2'd0, tsd_pkg::CODE_PAUSE});
                        track_bytes.push_back(8'h00);
                    end
                    1:
                        track_bytes.push_back({tsd_pkg::SPECIAL_STOP, tsd_pkg::CODE_SPECIAL});
                    default:
                        track_bytes.push_back({tsd_pkg::SPECIAL_END, tsd_pkg::CODE_SPECIAL});
                endcase
            end
            else
                track_bytes.push_back({tsd_pkg::SPECIAL_UNDEF, tsd_pkg::CODE_SPECIAL});
        end
        if (halted)
        begin
            // Trail up to two bytes the stopped track must drop
            repeat ($urandom_range(0, 2)) track_bytes.push_back(8'($urandom));
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            lo = 6'($urandom_range(0, 60));
            track_bytes.push_back({top, lo});
        end
    endtask

    task automatic test_note_rows;
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        // Highest note, all volume and instrument bits set, ends the track
        send_byte(8'hFC, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_volume_speed;
        send_byte({2'd1, tsd_pkg::CODE_VOLUME}, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte({2'd0, tsd_pkg::CODE_SPECIAL}, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte({2'd0, tsd_pkg::CODE_SPECIAL}, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    task automatic test_pauses;
        send_byte({2'd1, tsd_pkg::CODE_PAUSE}, 1'b0);
        send_byte({2'd2, tsd_pkg::CODE_PAUSE}, 1'b0);
        send_byte({2'd3, tsd_pkg::CODE_PAUSE}, 1'b0);
        // Long pause far enough to wrap the row counter
        send_byte({2'd0, tsd_pkg::CODE_PAUSE}, 1'b0);
        send_byte(8'hFF, 1'b0);
        // Infinite pause stops the track; later bytes are dropped
        send_byte({2'd0, tsd_pkg::CODE_PAUSE}, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h55, 1'b1);
    endtask

    task automatic test_special_codes;
        send_byte({tsd_pkg::SPECIAL_END, tsd_pkg::CODE_SPECIAL}, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte({tsd_pkg::SPECIAL_UNDEF, tsd_pkg::CODE_SPECIAL}, 1'b0);
        send_byte(8'h0A, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte({2'd1, tsd_pkg::CODE_PAUSE}, 1'b0);
        send_byte({tsd_pkg::SPECIAL_END, tsd_pkg::CODE_SPECIAL}, 1'b0);
        send_byte(8'h33, 1'b1);
    endtask

    task automatic test_final_byte;
        send_byte({2'd1, tsd_pkg::CODE_PAUSE}, 1'b1);
        send_byte({tsd_pkg::SPECIAL_UNDEF, tsd_pkg::CODE_SPECIAL}, 1'b1);
        // First byte of a two-byte token on the final item is dropped
        send_byte(8'h41, 1'b1);
        send_byte({tsd_pkg::SPECIAL_STOP, tsd_pkg::CODE_SPECIAL}, 1'b1);
        wait_drained();
    endtask

    task automatic test_output_hold;
        int         k;
        logic [7:0] first_b;
        logic [7:0] second_b;
        idling   = 1'b0;
        hold_req = 1'b1;
        for (k = 0; k < 12; k++)
        begin
            first_b  = 8'(k);
            second_b = 8'($urandom);
            send_byte({2'd2, first_b[5:0]}, 1'b0);
            send_byte(second_b, 1'b0);
        end
        send_byte({tsd_pkg::SPECIAL_STOP, tsd_pkg::CODE_SPECIAL}, 1'b1);
        wait_drained();
        idling = 1'b1;
    endtask

    task automatic test_random_tracks(input int n_items);
        int start;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            build_track();
            foreach (track_bytes[i])
                send_byte(track_bytes[i], i == track_bytes.size() - 1);
            if ($urandom_range(0, 3) == 0)
                wait_drained();
        end
    endtask

    // Receiver: random stall bursts, plus the long hold-off when asked
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_active)
                out_stall <= 1'b1;
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (idling && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 10) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_active = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active = 1'b0;
                hold_req    = 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_events.size() == 0)
                report_mismatch($sformatf("event kind %0d row %0d with none expected",
                                          event_kind, row_index));
            else
            begin
                want_event = expected_events.pop_front();
                check_field("event_kind", 8'(event_kind), 8'(want_event.kind));
                check_field("row_index", row_index, want_event.row);
                check_field("note_value", 8'(note_value), 8'(want_event.note));
                check_field("instrument_number", 8'(instrument_number),
                            8'(want_event.instrument));
                check_field("volume_level", 8'(volume_level), 8'(want_event.volume));
                check_field("speed_value", speed_value, want_event.speed);
                check_field("track_done", 8'(track_done), 8'(want_event.done));
                events_checked++;
            end
        end
    end

    initial
    begin
        clear_track();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_note_rows();
        test_volume_speed();
        test_pauses();
        test_special_codes();
        test_final_byte();
        test_random_tracks(200);
        test_output_hold();
        test_random_tracks(100);
        wait_drained();

        // Closing stretch streams without idling on either side
        idling = 1'b0;
        test_random_tracks(90);
        wait_drained();

        if (expected_events.size() != 0)
            report_mismatch($sformatf("%0d expected events never arrived",
                                      expected_events.size()));
        $display("Sent %0d track bytes in %0d tracks; %0d events compared.",
                 items_sent, tracks_sent, events_checked);
        $display("Covered token types, stops, final-byte cases, hold-off and drain pauses.");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
